@@ hw/rtl/cbib_pkg.sv @@
// ============================================================================
// cbib_pkg
// Shared types, constants and the CRC byte step for the card block image
// builder.
// ============================================================================
package cbib_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int TOTAL_W     = 11;

    localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_PAYLOAD);

    localparam logic [6:0]  FIRST_BLOCK  = 7'd9;
    localparam logic [6:0]  END_BLOCK    = 7'd64;
    localparam logic [5:0]  HEADER_BLOCK = 6'd8;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    localparam logic [7:0]  MAGIC_0    = 8'h42;
    localparam logic [7:0]  MAGIC_1    = 8'h4E;
    localparam logic [7:0]  MAGIC_2    = 8'h52;
    localparam logic [7:0]  MAGIC_3    = 8'h32;
    localparam logic [7:0]  HDR_FORMAT = 8'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_NO_BLOCKS = 2'd2,
        KIND_TOO_LONG  = 2'd3
    } kind_t;

    // One queued command: a data block, optionally followed by a header,
    // or a single error result.
    typedef struct packed {
        logic              err;
        kind_t             err_kind;
        logic              has_hdr;
        logic [5:0]        addr;
        logic [127:0]      data;
        logic [7:0]        entry;
        logic [TOTAL_W-1:0] length;
        logic [15:0]       crc;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/cbib_if.sv @@
// ============================================================================
// cbib_if
// Valid/ready channels for payload bytes in and block images out.
// ============================================================================
interface cbib_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cbib_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  block_addr;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [1:0]  kind;
    logic        run_end;

    modport source (output valid, output block_addr, output data_low, output data_high,
                    output kind, output run_end, input ready);
    modport sink   (input valid, input block_addr, input data_low, input data_high,
                    input kind, input run_end, output ready);
endinterface

@@ hw/rtl/card_block_image_builder.sv @@
// ============================================================================
// card_block_image_builder
// Packs a payload byte stream into 16-byte card block images with a
// CRC16-CCITT header block.
// ============================================================================
// One payload byte is taken per cycle; the front updates the CRC, count and
// partial block in that cycle and queues a command whenever a block fills,
// the last byte arrives or an error is found. The back turns each command
// into result items, one per cycle while the output is not stalled, so the
// last byte of a payload yields two output items (final data block, then
// the header for block 8). The four-entry command queue absorbs that second
// item and output stalls; input ready drops only while the queue is full.
// entry_count is sampled when the last byte is taken.
module card_block_image_builder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    cbib_in_if.sink     in_ch,
    cbib_out_if.source  out_ch
);

    logic [7:0]           entry_count_reg;
    logic                 push;
    logic                 pop;
    cbib_pkg::cmd_t       push_cmd;
    cbib_pkg::cmd_t       head_cmd;
    cbib_pkg::q_stat_t    q_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    cbib_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .entry_count (entry_count_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    cbib_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    cbib_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

@@ hw/rtl/cbib_queue.sv @@
// ============================================================================
// cbib_queue
// Small command queue between the front and the back.
// ============================================================================
module cbib_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cbib_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output cbib_pkg::cmd_t        head_cmd,
    output cbib_pkg::q_stat_t     stat
);

    cbib_pkg::cmd_t                   entry_reg [cbib_pkg::QUEUE_DEPTH];
    logic [cbib_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cbib_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cbib_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (cbib_pkg::QUEUE_AW+1)'(cbib_pkg::QUEUE_DEPTH));
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/cbib_front.sv @@
// ============================================================================
// cbib_front
// Takes payload bytes, keeps CRC, count and the partial block, and queues
// block, header and error commands.
// ============================================================================
module cbib_front
(
    input  logic                clk,
    input  logic                rst_n,
    cbib_in_if.sink             in_ch,
    input  logic [7:0]          entry_count,
    input  cbib_pkg::q_stat_t   q_stat,
    output logic                push,
    output cbib_pkg::cmd_t      push_cmd
);

    logic [15:0]                    crc_reg, crc_next;
    logic [cbib_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [6:0]                     block_reg, block_next;
    logic [3:0]                     fill_reg, fill_next;
    logic                           fault_reg, fault_next;
    logic [7:0]                     bytes_reg [16];

    logic                           accept;
    logic                           too_long;
    logic                           no_blocks;
    logic                           emit;
    logic [15:0]                    crc_upd;
    logic [cbib_pkg::TOTAL_W-1:0]   total_upd;
    logic [6:0]                     block_inc;
    logic [127:0]                   block_data;

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign too_long  = (total_reg >= cbib_pkg::MAX_TOTAL);
    assign no_blocks = (fill_reg == 4'd0) && (block_reg >= cbib_pkg::END_BLOCK);
    assign crc_upd   = cbib_pkg::crc_byte(crc_reg, in_ch.data_byte);
    assign total_upd = total_reg + 1'b1;
    assign emit      = (fill_reg == 4'd15) || in_ch.last_byte;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) == fill_reg)
            begin
                block_data[8*i +: 8] = in_ch.data_byte;
            end
            else if (4'(i) < fill_reg)
            begin
                block_data[8*i +: 8] = bytes_reg[i];
            end
            else
            begin
                block_data[8*i +: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        block_inc = block_reg + 7'd1;
        if (block_inc[1:0] == 2'd3)
        begin
            block_inc = block_inc + 7'd1;
        end
        if (block_inc > cbib_pkg::END_BLOCK)
        begin
            block_inc = cbib_pkg::END_BLOCK;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        total_next = total_reg;
        block_next = block_reg;
        fill_next  = fill_reg;
        fault_next = fault_reg;
        push       = 1'b0;

        push_cmd.err      = 1'b0;
        push_cmd.err_kind = too_long ? cbib_pkg::KIND_TOO_LONG : cbib_pkg::KIND_NO_BLOCKS;
        push_cmd.has_hdr  = in_ch.last_byte;
        push_cmd.addr     = block_reg[5:0];
        push_cmd.data     = block_data;
        push_cmd.entry    = entry_count;
        push_cmd.length   = total_upd;
        push_cmd.crc      = crc_upd;

        if (accept)
        begin
            if (fault_reg)
            begin
                if (in_ch.last_byte)
                begin
                    fault_next = 1'b0;
                end
            end
            else if (too_long || no_blocks)
            begin
                push         = 1'b1;
                push_cmd.err = 1'b1;
                crc_next     = cbib_pkg::CRC_SEED;
                total_next   = '0;
                block_next   = cbib_pkg::FIRST_BLOCK;
                fill_next    = 4'd0;
                fault_next   = !in_ch.last_byte;
            end
            else
            begin
                crc_next   = crc_upd;
                total_next = total_upd;
                fill_next  = fill_reg + 4'd1;
                if (emit)
                begin
                    push       = 1'b1;
                    fill_next  = 4'd0;
                    block_next = block_inc;
                end
                if (in_ch.last_byte)
                begin
                    crc_next   = cbib_pkg::CRC_SEED;
                    total_next = '0;
                    block_next = cbib_pkg::FIRST_BLOCK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= cbib_pkg::CRC_SEED;
            total_reg <= '0;
            block_reg <= cbib_pkg::FIRST_BLOCK;
            fill_reg  <= 4'd0;
            fault_reg <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            total_reg <= total_next;
            block_reg <= block_next;
            fill_reg  <= fill_next;
            fault_reg <= fault_next;
        end
    end

    // bytes above the fill level are masked on emit, so no clearing here
    always_ff @(posedge clk)
    begin
        if (accept && !fault_reg && !too_long && !no_blocks)
        begin
            bytes_reg[fill_reg] <= in_ch.data_byte;
        end
    end

endmodule

@@ hw/rtl/cbib_back.sv @@
// ============================================================================
// cbib_back
// Expands queued commands into result items behind an output register.
// ============================================================================
module cbib_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  cbib_pkg::cmd_t      head_cmd,
    input  cbib_pkg::q_stat_t   q_stat,
    output logic                pop,
    cbib_out_if.source          out_ch
);

    logic                           valid_reg, valid_next;
    logic                           hdr_pend_reg, hdr_pend_next;
    logic [5:0]                     addr_reg, addr_next;
    logic [63:0]                    low_reg, low_next;
    logic [63:0]                    high_reg, high_next;
    cbib_pkg::kind_t                kind_reg, kind_next;
    logic                           end_reg, end_next;
    logic [7:0]                     hdr_entry_reg, hdr_entry_next;
    logic [cbib_pkg::TOTAL_W-1:0]   hdr_len_reg, hdr_len_next;
    logic [15:0]                    hdr_crc_reg, hdr_crc_next;
    logic                           out_free;

    assign out_free = !valid_reg || out_ch.ready;
    assign pop      = out_free && !hdr_pend_reg && !q_stat.empty;

    assign out_ch.valid      = valid_reg;
    assign out_ch.block_addr = addr_reg;
    assign out_ch.data_low   = low_reg;
    assign out_ch.data_high  = high_reg;
    assign out_ch.kind       = kind_reg;
    assign out_ch.run_end    = end_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        hdr_pend_next  = hdr_pend_reg;
        addr_next      = addr_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        kind_next      = kind_reg;
        end_next       = end_reg;
        hdr_entry_next = hdr_entry_reg;
        hdr_len_next   = hdr_len_reg;
        hdr_crc_next   = hdr_crc_reg;

        if (out_free)
        begin
            valid_next = 1'b0;
            if (hdr_pend_reg)
            begin
                valid_next    = 1'b1;
                hdr_pend_next = 1'b0;
                addr_next     = cbib_pkg::HEADER_BLOCK;
                low_next      = {8'h00, hdr_entry_reg, 8'h00, cbib_pkg::HDR_FORMAT,
                                 cbib_pkg::MAGIC_3, cbib_pkg::MAGIC_2,
                                 cbib_pkg::MAGIC_1, cbib_pkg::MAGIC_0};
                high_next     = {32'h0, hdr_crc_reg, 16'(hdr_len_reg)};
                kind_next     = cbib_pkg::KIND_HEADER;
                end_next      = 1'b1;
            end
            else if (!q_stat.empty)
            begin
                valid_next = 1'b1;
                if (head_cmd.err)
                begin
                    addr_next = '0;
                    low_next  = '0;
                    high_next = '0;
                    kind_next = head_cmd.err_kind;
                    end_next  = 1'b1;
                end
                else
                begin
                    addr_next      = head_cmd.addr;
                    low_next       = head_cmd.data[63:0];
                    high_next      = head_cmd.data[127:64];
                    kind_next      = cbib_pkg::KIND_DATA;
                    end_next       = !head_cmd.has_hdr;
                    hdr_pend_next  = head_cmd.has_hdr;
                    hdr_entry_next = head_cmd.entry;
                    hdr_len_next   = head_cmd.length;
                    hdr_crc_next   = head_cmd.crc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            hdr_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            hdr_pend_reg <= hdr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        kind_reg      <= kind_next;
        end_reg       <= end_next;
        hdr_entry_reg <= hdr_entry_next;
        hdr_len_reg   <= hdr_len_next;
        hdr_crc_reg   <= hdr_crc_next;
    end

endmodule
